// File: rtl/core/pcm_diff_peak_average_assert.svh
// Assertion macros for the PCM difference, peak and mean block
`ifndef PCM_DIFF_PEAK_AVERAGE_ASSERT_SVH
`define PCM_DIFF_PEAK_AVERAGE_ASSERT_SVH

`ifndef SYNTHESIS

`define PCM_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("implication check failed");

`define PCM_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define PCM_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons)
`define PCM_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons)

`endif

`endif

// File: rtl/core/pcmdpa_pkg.sv
// Shared widths, codes, types and helpers of the PCM difference, peak and mean block
package pcmdpa_pkg;

	localparam int unsigned MAX_CHANNELS_DEF = 8;

	localparam int unsigned CH_W    = 3;
	localparam int unsigned SMP_W   = 32;
	localparam int unsigned DIFF_W  = 33;
	localparam int unsigned PEAK_W  = 33;
	localparam int unsigned FRAME_W = 32;
	localparam int unsigned AVG_W   = 49;
	localparam int unsigned NUM_W   = 50;
	localparam int unsigned REM_W   = 33;
	localparam int unsigned ALU_W   = 51;
	localparam int unsigned CNT_W   = 4;
	localparam int unsigned SIZE_W  = 3;
	localparam int unsigned FRAC_SH = 16;

	localparam int unsigned DIV_STEPS = NUM_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

	localparam int unsigned IN_W  = 72;
	localparam int unsigned OUT_W = 152;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = CNT_W;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_A        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_B        = 2'd2;

	localparam logic [CNT_W-1:0]  CHANNEL_COUNT_RST = 4'd1;
	localparam logic [SIZE_W-1:0] SIZE_RST          = 3'd2;

	typedef enum logic [1:0] {
		ALU_ADD  = 2'd0,
		ALU_SUB  = 2'd1,
		ALU_SUBB = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic               en;
		logic               peak_en;
		logic               frame_adv;
		logic [CH_W-1:0]    idx;
		logic [PEAK_W-1:0]  peak;
		logic [FRAME_W-1:0] frame;
		logic [AVG_W-1:0]   avg;
	} store_wr_t;

	function automatic logic [SMP_W-1:0] normalize(input logic [SMP_W-1:0] raw,
			input logic [SIZE_W-1:0] size);
		logic [SMP_W-1:0] v;
		case (size) inside
			3'd0, 3'd1: v = {raw[7:0], 24'd0};
			3'd2:       v = {raw[15:0], 16'd0};
			3'd3:       v = {raw[23:0], 8'd0};
			default:    v = raw;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/pcmdpa_alu.sv
// Shared add and subtract unit used by every arithmetic step of the sequencer
module pcmdpa_alu (
	input  pcmdpa_pkg::alu_op_t                op,
	input  logic [pcmdpa_pkg::ALU_W-1:0]       a,
	input  logic [pcmdpa_pkg::ALU_W-1:0]       b,
	output logic [pcmdpa_pkg::ALU_W-1:0]       res
);

	logic [pcmdpa_pkg::ALU_W-1:0] b_eff;
	logic                         cin;

	always_comb begin
		unique case (op)
			pcmdpa_pkg::ALU_ADD: begin
				b_eff = b;
				cin   = 1'b0;
			end
			pcmdpa_pkg::ALU_SUB: begin
				b_eff = ~b;
				cin   = 1'b1;
			end
			pcmdpa_pkg::ALU_SUBB: begin
				b_eff = ~b;
				cin   = 1'b0;
			end
			default: begin
				b_eff = b;
				cin   = 1'b0;
			end
		endcase
	end

	assign res = a + b_eff + pcmdpa_pkg::ALU_W'(cin);

endmodule

// File: rtl/core/pcmdpa_store.sv
// Per-channel peak, peak frame and mean stores with the saturating frame counter
module pcmdpa_store #(
	parameter int unsigned STORE_DEPTH = pcmdpa_pkg::MAX_CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pcmdpa_pkg::store_wr_t               wr,
	input  logic [pcmdpa_pkg::CH_W-1:0]         rd_idx,
	output logic [pcmdpa_pkg::PEAK_W-1:0]       rd_peak,
	output logic [pcmdpa_pkg::FRAME_W-1:0]      rd_frame,
	output logic [pcmdpa_pkg::AVG_W-1:0]        rd_avg,
	output logic [pcmdpa_pkg::FRAME_W-1:0]      frame_count
);

	localparam int unsigned IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [pcmdpa_pkg::PEAK_W-1:0]  peak_q  [STORE_DEPTH];
	logic [pcmdpa_pkg::FRAME_W-1:0] pframe_q[STORE_DEPTH];
	logic [pcmdpa_pkg::AVG_W-1:0]   avg_q   [STORE_DEPTH];
	logic [pcmdpa_pkg::FRAME_W-1:0] frame_q;

	logic [IW-1:0] wr_i;
	logic [IW-1:0] rd_i;

	assign wr_i = wr.idx[IW-1:0];
	assign rd_i = rd_idx[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				peak_q[i]   <= '0;
				pframe_q[i] <= '0;
				avg_q[i]    <= '0;
			end
			frame_q <= '0;
		end else begin
			if (wr.en) begin
				avg_q[wr_i] <= wr.avg;
				if (wr.peak_en) begin
					peak_q[wr_i]   <= wr.peak;
					pframe_q[wr_i] <= wr.frame;
				end
			end
			if (wr.frame_adv && (frame_q != '1)) begin
				frame_q <= frame_q + 1'b1;
			end
		end
	end

	assign rd_peak     = peak_q[rd_i];
	assign rd_frame    = pframe_q[rd_i];
	assign rd_avg      = avg_q[rd_i];
	assign frame_count = frame_q;

endmodule

// File: rtl/core/pcm_diff_peak_average.sv
// Top level: stream ports, configuration registers and the step sequencer
// Usage:
// Slave channel s_* takes one sample pair per beat (channel, sample_a, sample_b).
// Master channel m_* gives one result per input beat: the normalised difference,
// the channel's peak |difference|, its frame and the running mean.
// Configuration (channel_count, size_a, size_b) is written through cfg_wr_en,
// cfg_index and cfg_data while no beat is in flight.
// s_tready returns in the cycle after the result is loaded; a new pair is not
// taken until the result of the last one is loaded into the output register.
// Each pass runs the 50-step restoring division of the mean update, one quotient
// bit a cycle on the single shared 51-bit adder, plus six set-up and wrap-up
// steps on the same adder and one output step.
// A finished result waits in the output register; while that register is full and
// m_tready is low, the sequencer holds the next result in its last step.
// Reset clears all channel stores, the frame counter and the output valid, and
// loads channel_count = 1, size_a = size_b = 2.
`include "pcm_diff_peak_average_assert.svh"

module pcm_diff_peak_average #(
	parameter int unsigned MAX_CHANNELS = pcmdpa_pkg::MAX_CHANNELS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// channel [2:0], sample_a [34:3], sample_b [66:35], zero fill above
	input  logic [pcmdpa_pkg::IN_W-1:0]           s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// diff_sample [32:0], peak_now [65:33], peak_frame_now [97:66],
	// average_now [146:98], zero fill above
	output logic [pcmdpa_pkg::OUT_W-1:0]          m_tdata,
	input  logic                                  cfg_wr_en,
	input  logic [pcmdpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pcmdpa_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned STORE_DEPTH = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
	localparam int unsigned CEW = $clog2(MAX_CHANNELS + 1);
	localparam int unsigned AW  = pcmdpa_pkg::ALU_W;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_DIFF = 9'b000000010,
		S_MAG  = 9'b000000100,
		S_PEAK = 9'b000001000,
		S_XSUB = 9'b000010000,
		S_NUM  = 9'b000100000,
		S_DIV  = 9'b001000000,
		S_FIN  = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [pcmdpa_pkg::CNT_W-1:0]   channel_count_q;
	logic [pcmdpa_pkg::SIZE_W-1:0]  size_a_q;
	logic [pcmdpa_pkg::SIZE_W-1:0]  size_b_q;

	logic [pcmdpa_pkg::CH_W-1:0]    ch_q;
	logic [pcmdpa_pkg::SMP_W-1:0]   na_q;
	logic [pcmdpa_pkg::SMP_W-1:0]   nb_q;
	logic [pcmdpa_pkg::DIFF_W-1:0]  d_q;
	logic [pcmdpa_pkg::PEAK_W-1:0]  mag_q;
	logic [pcmdpa_pkg::PEAK_W-1:0]  peak_rd_q;
	logic [pcmdpa_pkg::FRAME_W-1:0] pframe_rd_q;
	logic [pcmdpa_pkg::AVG_W-1:0]   avg_rd_q;
	logic                           gt_q;
	logic                           ge_q;
	logic [AW-1:0]                  t_q;
	logic [pcmdpa_pkg::NUM_W-1:0]   num_q;
	logic [pcmdpa_pkg::REM_W-1:0]   rem_q;
	logic [pcmdpa_pkg::STEP_W-1:0]  step_q;
	logic [pcmdpa_pkg::AVG_W-1:0]   avg_new_q;

	logic                           m_tvalid_q;
	logic [pcmdpa_pkg::OUT_W-1:0]   m_tdata_q;

	pcmdpa_pkg::alu_op_t            alu_op;
	logic [AW-1:0]                  alu_a;
	logic [AW-1:0]                  alu_b;
	logic [AW-1:0]                  alu_res;

	pcmdpa_pkg::store_wr_t          st_wr;
	logic [pcmdpa_pkg::PEAK_W-1:0]  st_peak;
	logic [pcmdpa_pkg::FRAME_W-1:0] st_frame;
	logic [pcmdpa_pkg::AVG_W-1:0]   st_avg;
	logic [pcmdpa_pkg::FRAME_W-1:0] frame_count;

	logic [pcmdpa_pkg::REM_W:0]     div_sh;
	logic [pcmdpa_pkg::AVG_W-1:0]   x_val;
	logic [CEW-1:0]                 cnt_eff;
	logic                           ch_ok;
	logic                           last_ch;
	logic                           out_free;
	logic                           out_load;
	logic                           s_acc;
	logic                           div_last;

	logic [pcmdpa_pkg::PEAK_W-1:0]  res_peak;
	logic [pcmdpa_pkg::FRAME_W-1:0] res_frame;
	logic [pcmdpa_pkg::AVG_W-1:0]   res_avg;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == S_OUT) && out_free;
	assign div_last = (state_q == S_DIV)
		&& (step_q == pcmdpa_pkg::STEP_W'(pcmdpa_pkg::DIV_STEPS - 1));

	assign div_sh = {rem_q, num_q[pcmdpa_pkg::NUM_W-1]};
	assign x_val  = {mag_q, pcmdpa_pkg::FRAC_SH'(0)};

	always_comb begin
		if (channel_count_q == '0) begin
			cnt_eff = CEW'(1);
		end else if (32'(channel_count_q) > MAX_CHANNELS) begin
			cnt_eff = CEW'(MAX_CHANNELS);
		end else begin
			cnt_eff = CEW'(channel_count_q);
		end
	end

	assign ch_ok   = (32'(ch_q) < MAX_CHANNELS);
	assign last_ch = ((8'(ch_q) + 8'd1) == 8'(cnt_eff));

	// operand selection for the shared adder
	always_comb begin
		alu_op = pcmdpa_pkg::ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			S_DIFF: begin
				alu_op = pcmdpa_pkg::ALU_SUB;
				alu_a  = {{(AW-pcmdpa_pkg::SMP_W){na_q[pcmdpa_pkg::SMP_W-1]}}, na_q};
				alu_b  = {{(AW-pcmdpa_pkg::SMP_W){nb_q[pcmdpa_pkg::SMP_W-1]}}, nb_q};
			end
			S_MAG: begin
				alu_op = pcmdpa_pkg::ALU_SUB;
				alu_b  = {{(AW-pcmdpa_pkg::DIFF_W){d_q[pcmdpa_pkg::DIFF_W-1]}}, d_q};
			end
			S_PEAK: begin
				alu_op = pcmdpa_pkg::ALU_SUB;
				alu_a  = AW'(peak_rd_q);
				alu_b  = AW'(mag_q);
			end
			S_XSUB: begin
				alu_op = pcmdpa_pkg::ALU_SUB;
				alu_a  = AW'(x_val);
				alu_b  = AW'(avg_rd_q);
			end
			S_NUM: begin
				if (ge_q) begin
					alu_op = pcmdpa_pkg::ALU_ADD;
					alu_a  = t_q;
				end else begin
					alu_op = pcmdpa_pkg::ALU_SUB;
					alu_a  = AW'(frame_count);
					alu_b  = t_q;
				end
			end
			S_DIV: begin
				alu_op = pcmdpa_pkg::ALU_SUBB;
				alu_a  = AW'(div_sh);
				alu_b  = AW'(frame_count);
			end
			S_FIN: begin
				alu_op = ge_q ? pcmdpa_pkg::ALU_ADD : pcmdpa_pkg::ALU_SUB;
				alu_a  = AW'(avg_rd_q);
				alu_b  = AW'(num_q);
			end
			default: begin
				alu_op = pcmdpa_pkg::ALU_ADD;
			end
		endcase
	end

	pcmdpa_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	always_comb begin
		res_peak  = gt_q ? mag_q : peak_rd_q;
		res_frame = gt_q ? frame_count : pframe_rd_q;
		res_avg   = avg_new_q;
		if (!ch_ok) begin
			res_peak  = '0;
			res_frame = '0;
			res_avg   = '0;
		end
	end

	always_comb begin
		st_wr.en        = out_load && ch_ok;
		st_wr.peak_en   = gt_q;
		st_wr.frame_adv = out_load && ch_ok && last_ch;
		st_wr.idx       = ch_q;
		st_wr.peak      = mag_q;
		st_wr.frame     = frame_count;
		st_wr.avg       = avg_new_q;
	end

	pcmdpa_store #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (st_wr),
		.rd_idx      (ch_q),
		.rd_peak     (st_peak),
		.rd_frame    (st_frame),
		.rd_avg      (st_avg),
		.frame_count (frame_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= pcmdpa_pkg::CHANNEL_COUNT_RST;
			size_a_q        <= pcmdpa_pkg::SIZE_RST;
			size_b_q        <= pcmdpa_pkg::SIZE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pcmdpa_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data;
				pcmdpa_pkg::REG_SIZE_A:        size_a_q <= cfg_data[pcmdpa_pkg::SIZE_W-1:0];
				pcmdpa_pkg::REG_SIZE_B:        size_b_q <= cfg_data[pcmdpa_pkg::SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (s_acc) state_q <= S_DIFF;
				S_DIFF: state_q <= S_MAG;
				S_MAG:  state_q <= S_PEAK;
				S_PEAK: state_q <= S_XSUB;
				S_XSUB: state_q <= S_NUM;
				S_NUM: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (div_last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN:  state_q <= S_OUT;
				S_OUT:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					ch_q <= s_tdata[2:0];
					na_q <= pcmdpa_pkg::normalize(s_tdata[34:3], size_a_q);
					nb_q <= pcmdpa_pkg::normalize(s_tdata[66:35], size_b_q);
				end
			end
			S_DIFF: begin
				d_q         <= alu_res[pcmdpa_pkg::DIFF_W-1:0];
				peak_rd_q   <= st_peak;
				pframe_rd_q <= st_frame;
				avg_rd_q    <= st_avg;
			end
			S_MAG: begin
				mag_q <= d_q[pcmdpa_pkg::DIFF_W-1] ? alu_res[pcmdpa_pkg::PEAK_W-1:0] : d_q;
			end
			S_PEAK: gt_q <= alu_res[AW-1];
			S_XSUB: begin
				t_q  <= alu_res;
				ge_q <= !alu_res[AW-1];
			end
			S_NUM: begin
				num_q <= alu_res[pcmdpa_pkg::NUM_W-1:0];
				rem_q <= '0;
			end
			S_DIV: begin
				if (!alu_res[AW-1]) begin
					rem_q <= alu_res[pcmdpa_pkg::REM_W-1:0];
					num_q <= {num_q[pcmdpa_pkg::NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= div_sh[pcmdpa_pkg::REM_W-1:0];
					num_q <= {num_q[pcmdpa_pkg::NUM_W-2:0], 1'b0};
				end
			end
			S_FIN: avg_new_q <= alu_res[pcmdpa_pkg::AVG_W-1:0];
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {5'd0, res_avg, res_frame, res_peak, d_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`PCM_ASSERT_NXT(a_accept_starts, clk, arst_n, s_acc, state_q == S_DIFF)
	`PCM_ASSERT_NXT(a_div_ends, clk, arst_n, div_last, state_q == S_FIN)
	`PCM_ASSERT_IMP(a_rem_below_den, clk, arst_n, state_q == S_DIV, rem_q <= {1'b0, frame_count})
	`PCM_ASSERT_NXT(a_load_shows, clk, arst_n, out_load, m_tvalid && (state_q == S_IDLE))
	`PCM_ASSERT_NXT(a_frame_monotone, clk, arst_n, 1'b1, frame_count >= $past(frame_count))

endmodule
